>>> design/fela_pkg.sv
// Package for the free extent list allocator.
// Holds widths, operation and status codes and the controller command word.
// No dependencies.
package fela_pkg;

    localparam int NBLOCKS = 4096;
    localparam int BLK_W   = 12;
    localparam int VOL_W   = 13;
    localparam int HDR_W   = 2 * BLK_W;

    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(NBLOCKS);

    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

>>> design/fela_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module fela_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/fela_ctrl.sv
// Controller for the free extent list allocator: accept, execute, strobe.
// Depends on fela_pkg.
module fela_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output fela_pkg::t_dp_cmd o_cmd
);
    import fela_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_cmd.load = i_start && (r_state == S_IDLE);
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

>>> design/fela_dp.sv
// Datapath for the free extent list allocator: head, count, volume size,
// header store and result registers. Depends on fela_pkg and fela_ram.
module fela_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fela_pkg::t_dp_cmd            i_cmd,
    input  logic [1:0]                   i_operation,
    input  logic [fela_pkg::BLK_W-1:0]   i_block,
    input  logic                         i_cfg_valid,
    input  logic [fela_pkg::VOL_W-1:0]   i_cfg_data,
    output logic [fela_pkg::BLK_W-1:0]   o_granted_block,
    output logic [1:0]                   o_status,
    output logic [fela_pkg::BLK_W-1:0]   o_free_count
);
    import fela_pkg::*;

    logic [BLK_W-1:0] r_head, n_head;
    logic [BLK_W-1:0] r_count, n_count;
    logic [VOL_W-1:0] r_vol;
    logic [1:0]       r_op;
    logic [BLK_W-1:0] r_blk;
    logic [BLK_W-1:0] r_granted, n_granted;
    logic [1:0]       r_status, n_status;

    logic [VOL_W-1:0] w_eff;
    logic [BLK_W-1:0] w_fmt_total;
    logic             w_bad;
    logic [HDR_W-1:0] w_rdata;
    logic [BLK_W-1:0] w_size;
    logic [BLK_W-1:0] w_next;
    logic             w_we;
    logic [BLK_W-1:0] w_waddr;
    logic [HDR_W-1:0] w_wdata;

    fela_ram #(
        .WIDTH (HDR_W),
        .DEPTH (NBLOCKS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign w_size = w_rdata[BLK_W-1:0];
    assign w_next = w_rdata[HDR_W-1:BLK_W];

    always_comb begin
        if (r_vol < VOL_W'(2)) begin
            w_eff = VOL_W'(2);
        end else if (r_vol > VOL_W'(NBLOCKS)) begin
            w_eff = VOL_W'(NBLOCKS);
        end else begin
            w_eff = r_vol;
        end
    end

    assign w_fmt_total = BLK_W'(w_eff - VOL_W'(1));
    assign w_bad       = (r_blk == '0) || ({1'b0, r_blk} >= w_eff);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_granted = '0;
        n_status  = ST_OK;
        w_we      = 1'b0;
        w_waddr   = r_blk;
        w_wdata   = {r_head, BLK_W'(1)};
        case (t_op'(r_op))
            OP_FORMAT: begin
                n_head  = BLK_W'(1);
                n_count = w_fmt_total;
                w_we    = i_cmd.exec;
                w_waddr = BLK_W'(1);
                w_wdata = {BLK_W'(0), w_fmt_total};
            end
            OP_ALLOC: begin
                if (r_count == '0 || r_head == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_granted = r_head;
                    n_count   = r_count - BLK_W'(1);
                    if (w_size == BLK_W'(1)) begin
                        n_head = w_next;
                    end else begin
                        n_head  = r_head + BLK_W'(1);
                        w_we    = i_cmd.exec;
                        w_waddr = r_head + BLK_W'(1);
                        w_wdata = {w_next, w_size - BLK_W'(1)};
                    end
                end
            end
            OP_FREE: begin
                if (w_bad) begin
                    n_status = ST_BAD;
                end else begin
                    n_head = r_blk;
                    w_we   = i_cmd.exec;
                    if (r_count != '1) begin
                        n_count = r_count + BLK_W'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_vol   <= VOL_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_vol <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_blk <= i_block;
        end
        if (i_cmd.exec) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    assign o_granted_block = r_granted;
    assign o_status        = r_status;
    assign o_free_count    = r_count;

endmodule

>>> design/free_extent_list_allocator.sv
// An accepted word passes the EXEC state and the done register to its result
// strobe. No new word is taken while busy: the header RAM read is followed by
// the header write and head update; start is taken again in the strobe cycle.
// Reset (synchronous, active low) clears head and free count and sets the
// volume size to 4096; the header store is not cleared. Results cannot stall.
// Top level; depends on fela_pkg, fela_ctrl, fela_dp and fela_ram.
module free_extent_list_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic [fela_pkg::BLK_W-1:0]   i_block,
    output logic                         o_done,
    output logic [fela_pkg::BLK_W-1:0]   o_granted_block,
    output logic [1:0]                   o_status,
    output logic [fela_pkg::BLK_W-1:0]   o_free_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fela_pkg::VOL_W-1:0]   i_cfg_data
);
    import fela_pkg::*;

    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    fela_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    fela_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_operation     (i_operation),
        .i_block         (i_block),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_granted_block (o_granted_block),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule

>>> design/fela_checker.sv
// Port-level checks for the free extent list allocator, bound to the top.
// Depends on fela_pkg.
module fela_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         o_done,
    input  logic [fela_pkg::BLK_W-1:0]   o_granted_block,
    input  logic [1:0]                   o_status
);
    import fela_pkg::*;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result strobe missing after accepted word");

    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted word");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted_block != '0) |-> (o_status == ST_OK))
        else $error("granted block with failing status");

endmodule

bind free_extent_list_allocator fela_checker u_fela_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_granted_block (o_granted_block),
    .o_status        (o_status)
);
